[design/bba_pkg.sv]
// Shared constants and types for the buddy block allocator.
`default_nettype none

package bba_pkg;

    localparam int NUM_ORDERS  = 7;
    localparam int PAGE_SHIFT  = 12;
    localparam int TOP_ORDER   = NUM_ORDERS - 1;
    localparam int FRAME_W     = TOP_ORDER;
    localparam int FRAME_COUNT = 1 << FRAME_W;
    localparam int ORD_W       = $clog2(NUM_ORDERS);
    localparam int WANT_W      = 3;
    localparam int STATUS_W    = 2;
    localparam int START_W     = 6;
    localparam int ADDR_W      = 32;
    localparam logic [ADDR_W-1:0] BASE_RESET = 32'h2000_0000;

    typedef enum logic [STATUS_W-1:0] {
        ST_GRANTED  = 2'd0,
        ST_INVALID  = 2'd1,
        ST_NO_SPACE = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_SPLIT,
        S_ADDR,
        S_OUT
    } t_state;

    typedef struct packed {
        logic               en;
        logic               set;
        logic [ORD_W-1:0]   ord;
        logic [FRAME_W-1:0] id;
    } t_map_cmd;

    typedef struct packed {
        logic               any;
        logic [FRAME_W-1:0] id;
    } t_map_rd;

    typedef struct packed {
        t_status             status;
        logic [START_W-1:0]  start_frame;
        logic [ADDR_W-1:0]   block_address;
    } t_result;

endpackage

`default_nettype wire

[design/bba_free_maps.sv]
// Per-order free bitmaps with a lowest-free-block finder on one read port.
`default_nettype none

module bba_free_maps (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire bba_pkg::t_map_cmd          i_cmd,
    input  wire logic [bba_pkg::ORD_W-1:0]  i_rd_ord,
    output bba_pkg::t_map_rd                o_rd
);

    logic [bba_pkg::FRAME_COUNT-1:0] r_map [bba_pkg::NUM_ORDERS];
    logic [bba_pkg::FRAME_COUNT-1:0] v;
    logic [bba_pkg::FRAME_COUNT-1:0] low;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < bba_pkg::NUM_ORDERS; k++) begin
                r_map[k] <= (k == bba_pkg::TOP_ORDER) ? bba_pkg::FRAME_COUNT'(1) : '0;
            end
        end else if (i_cmd.en) begin
            r_map[i_cmd.ord][i_cmd.id] <= i_cmd.set;
        end
    end

    always_comb begin
        v   = r_map[i_rd_ord];
        low = v & (~v + bba_pkg::FRAME_COUNT'(1));
        o_rd.any = |v;
        o_rd.id  = '0;
        for (int b = 0; b < bba_pkg::FRAME_W; b++) begin
            for (int i = 0; i < bba_pkg::FRAME_COUNT; i++) begin
                if (((i >> b) & 1) != 0) begin
                    o_rd.id[b] = o_rd.id[b] | low[i];
                end
            end
        end
    end

endmodule

`default_nettype wire

[design/bba_seq.sv]
// Sequencer: order search, split walk, address add and result register.
`default_nettype none

module bba_seq (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [bba_pkg::WANT_W-1:0]    i_order_wanted,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output bba_pkg::t_result                   o_result,
    input  wire logic [bba_pkg::ADDR_W-1:0]    i_region_base,
    output bba_pkg::t_map_cmd                  o_cmd,
    output logic [bba_pkg::ORD_W-1:0]          o_rd_ord,
    input  wire bba_pkg::t_map_rd              i_rd
);

    localparam logic [bba_pkg::ORD_W-1:0] TOP_ORD = bba_pkg::ORD_W'(bba_pkg::TOP_ORDER);
    localparam int SHIFT_W = bba_pkg::FRAME_W + bba_pkg::PAGE_SHIFT + bba_pkg::ADDR_W;
    localparam int EXT_W   = bba_pkg::FRAME_W + bba_pkg::START_W;

    bba_pkg::t_state r_state, n_state;
    logic [bba_pkg::ORD_W-1:0]   r_ord, n_ord;
    logic [bba_pkg::ORD_W-1:0]   r_want, n_want;
    logic [bba_pkg::FRAME_W-1:0] r_id, n_id;
    bba_pkg::t_result            r_res, n_res;

    logic                        in_fire;
    logic                        want_bad;
    logic [bba_pkg::FRAME_W-1:0] start;
    logic [EXT_W-1:0]            start_ext;
    logic [SHIFT_W-1:0]          offset;

    assign in_fire  = i_in_valid && o_in_ready;
    assign want_bad = 32'(i_order_wanted) >= 32'(bba_pkg::NUM_ORDERS);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bba_pkg::S_IDLE: begin
                if (in_fire) begin
                    n_state = want_bad ? bba_pkg::S_OUT : bba_pkg::S_SEARCH;
                end
            end
            bba_pkg::S_SEARCH: begin
                if (i_rd.any) begin
                    n_state = (r_ord == r_want) ? bba_pkg::S_ADDR : bba_pkg::S_SPLIT;
                end else if (r_ord == TOP_ORD) begin
                    n_state = bba_pkg::S_OUT;
                end
            end
            bba_pkg::S_SPLIT: begin
                if (r_ord - 1'b1 == r_want) begin
                    n_state = bba_pkg::S_ADDR;
                end
            end
            bba_pkg::S_ADDR: n_state = bba_pkg::S_OUT;
            bba_pkg::S_OUT: begin
                if (i_out_ready) begin
                    n_state = bba_pkg::S_IDLE;
                end
            end
            default: n_state = bba_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_ord       = r_ord;
        n_want      = r_want;
        n_id        = r_id;
        n_res       = r_res;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_rd_ord    = r_ord;
        o_cmd       = '0;
        start       = bba_pkg::FRAME_W'(r_id << r_want);
        start_ext   = {{bba_pkg::START_W{1'b0}}, start};
        offset      = {{(bba_pkg::PAGE_SHIFT + bba_pkg::ADDR_W){1'b0}}, start}
                      << bba_pkg::PAGE_SHIFT;
        unique case (r_state)
            bba_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                n_ord  = bba_pkg::ORD_W'(i_order_wanted);
                n_want = bba_pkg::ORD_W'(i_order_wanted);
                n_res  = '{status: bba_pkg::ST_INVALID, start_frame: '0, block_address: '0};
            end
            bba_pkg::S_SEARCH: begin
                if (i_rd.any) begin
                    n_id      = i_rd.id;
                    o_cmd.en  = 1'b1;
                    o_cmd.set = 1'b0;
                    o_cmd.ord = r_ord;
                    o_cmd.id  = i_rd.id;
                end else if (r_ord == TOP_ORD) begin
                    n_res.status = bba_pkg::ST_NO_SPACE;
                end else begin
                    n_ord = r_ord + 1'b1;
                end
            end
            bba_pkg::S_SPLIT: begin
                n_ord     = r_ord - 1'b1;
                n_id      = {r_id[bba_pkg::FRAME_W-2:0], 1'b0};
                o_cmd.en  = 1'b1;
                o_cmd.set = 1'b1;
                o_cmd.ord = r_ord - 1'b1;
                o_cmd.id  = {r_id[bba_pkg::FRAME_W-2:0], 1'b1};
            end
            bba_pkg::S_ADDR: begin
                n_res.status        = bba_pkg::ST_GRANTED;
                n_res.start_frame   = start_ext[bba_pkg::START_W-1:0];
                n_res.block_address = i_region_base + offset[bba_pkg::ADDR_W-1:0];
            end
            bba_pkg::S_OUT: o_out_valid = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bba_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ord  <= n_ord;
        r_want <= n_want;
        r_id   <= n_id;
        r_res  <= n_res;
    end

    assign o_result = r_res;

    a_no_accept_while_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !o_out_valid)
        else $error("item taken while a result waits");

    a_bad_order_direct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && want_bad) |=> (o_out_valid && o_result.status == bba_pkg::ST_INVALID))
        else $error("invalid order not reported at once");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_result.status != bba_pkg::ST_GRANTED)
        |-> (o_result.start_frame == '0 && o_result.block_address == '0))
        else $error("rejected result carries a block");

    a_split_above_want: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bba_pkg::S_SPLIT) |-> (r_ord > r_want))
        else $error("split below requested order");

    a_map_write_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.en |-> (r_state == bba_pkg::S_SEARCH || r_state == bba_pkg::S_SPLIT))
        else $error("free map written outside search or split");

endmodule

`default_nettype wire

[design/buddy_block_allocator_core.sv]
// Top level of the buddy block allocator: ports, base register and wiring.
// Invalid order: result in the cycle after acceptance. Else the search climbs from
// requested order w to the first order j with a free block (no space past the top),
// splits j down to w, adds the address. One search step or one split level a cycle.
// One item at a time: the next item is taken the cycle after the result is taken.
// Synchronous active-low reset: one free top-order block, base 0x20000000.
`default_nettype none

module buddy_block_allocator_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // [2:0] order_wanted, [7:3] zero
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [39:0]      o_m_axis_tdata,   // [1:0] status, [7:2] start_frame,
                                               // [39:8] block_address
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [31:0] i_cfg_data        // region_base
);

    logic [bba_pkg::ADDR_W-1:0] r_region_base;
    bba_pkg::t_map_cmd          cmd;
    bba_pkg::t_map_rd           rd;
    logic [bba_pkg::ORD_W-1:0]  rd_ord;
    bba_pkg::t_result           result;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_region_base <= bba_pkg::BASE_RESET;
        end else if (i_cfg_valid) begin
            r_region_base <= i_cfg_data;
        end
    end

    bba_free_maps u_maps (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_rd_ord (rd_ord),
        .o_rd     (rd)
    );

    bba_seq u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_s_axis_tvalid),
        .o_in_ready     (o_s_axis_tready),
        .i_order_wanted (i_s_axis_tdata[2:0]),
        .o_out_valid    (o_m_axis_tvalid),
        .i_out_ready    (i_m_axis_tready),
        .o_result       (result),
        .i_region_base  (r_region_base),
        .o_cmd          (cmd),
        .o_rd_ord       (rd_ord),
        .i_rd           (rd)
    );

    assign o_m_axis_tdata = {result.block_address, result.start_frame, result.status};

endmodule

`default_nettype wire
